>>> rtl/pwc_pkg.sv
package pwc_pkg;

  // Word store geometry
  localparam int MAX_WORD   = 64;
  localparam int ADDR_W     = $clog2(MAX_WORD);
  localparam int LEN_W      = ADDR_W + 1;

  // Count and field widths
  localparam int COUNT_BITS = 32;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_DATA_W-1:0] MIN_LEN_RESET = 7'd2;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;

  // ASCII codes used by the tokenizer
  localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'd65;
  localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'd90;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH      = 2'd0,
    CFG_LENGTH_CHECK_ON = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } pwc_state_t;

  // Word separators: space : , ; . - newline tab return # and NUL
  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    return b inside {8'h20, 8'h3A, 8'h2C, 8'h3B, 8'h2E, 8'h2D,
                     8'h0A, 8'h09, 8'h0D, 8'h23, 8'h00};
  endfunction

  // Fold A-Z to lower case, leave everything else alone
  function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] b);
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

endpackage

>>> rtl/pwc_in_if.sv
interface pwc_in_if import pwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> rtl/pwc_out_if.sv
interface pwc_out_if import pwc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  word_done;
  logic                  word_counted;
  logic [COUNT_BITS-1:0] palindrome_count;

  modport source (output valid, output word_done, output word_counted,
                  output palindrome_count, input ready);
  modport sink   (input valid, input word_done, input word_counted,
                  input palindrome_count, output ready);
endinterface

>>> rtl/palindrome_word_counter_unit.sv
// Palindrome word counter: takes one text byte per input beat, splits the
// stream into words at space : , ; . - newline tab return # and NUL, folds
// A-Z to lower case and counts mirror palindromes longer than min_length
// (or any palindrome when length_check_on is 0); words over 64 bytes never
// count and the count saturates. Every input beat gives exactly one result
// beat. The compare walk reads both ends of the word from a dual-read store
// and checks one byte pair at a time on a single comparator, stopping at the
// first mismatch. Input is not ready while a word is checked or a result is
// being handed over.
module palindrome_word_counter_unit import pwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pwc_in_if.sink                in_ch,
  pwc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pwc_state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] min_len_r;
  logic                  len_chk_r;

  logic [LEN_W-1:0]      len_r;
  logic                  ovf_r;
  logic                  done_r;
  logic                  match_r;
  logic [ADDR_W-1:0]     lo_r;
  logic [ADDR_W-1:0]     hi_r;
  logic [COUNT_BITS-1:0] total_r;

  logic                  out_valid_r;
  logic                  out_done_r;
  logic                  out_counted_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic                  in_fire;
  logic                  byte_delim;
  logic [BYTE_W-1:0]     byte_folded;
  logic                  room;
  logic                  wr_en;
  logic [LEN_W-1:0]      len_acc;
  logic                  ovf_acc;
  logic                  close_acc;
  logic                  walk_acc;
  logic [LEN_W-1:0]      hi_start;
  logic [BYTE_W-1:0]     rd_a;
  logic [BYTE_W-1:0]     rd_b;
  logic                  pair_eq;
  logic [LEN_W-1:0]      lo_inc;
  logic [LEN_W-1:0]      hi_dec;
  logic                  walk_more;
  logic                  out_free;
  logic                  load_out;
  logic                  counted;
  logic [COUNT_BITS-1:0] total_nxt;

  // Tokenize the incoming byte
  always_comb begin
    byte_delim  = is_delim(in_ch.text_byte);
    byte_folded = fold_lower(in_ch.text_byte);
    room        = (len_r < LEN_W'(MAX_WORD));
    len_acc     = len_r;
    ovf_acc     = ovf_r;
    if (!byte_delim) begin
      if (room) begin
        len_acc = len_r + LEN_W'(1);
      end else begin
        ovf_acc = 1'b1;
      end
    end
    close_acc = (byte_delim || in_ch.end_of_text) && (len_acc != '0 || ovf_acc);
    walk_acc  = close_acc && !ovf_acc && (len_acc > LEN_W'(1));
    hi_start  = len_acc - LEN_W'(1);
  end

  // Compare unit and walk bounds
  always_comb begin
    pair_eq   = (rd_a == rd_b);
    lo_inc    = {1'b0, lo_r} + LEN_W'(1);
    hi_dec    = {1'b0, hi_r} - LEN_W'(1);
    walk_more = pair_eq && (lo_inc < hi_dec);
  end

  // Decide and apply the count for a closed word
  always_comb begin
    counted   = done_r && match_r && !ovf_r &&
                (!len_chk_r || (len_r > LEN_W'(min_len_r)));
    total_nxt = total_r;
    if (counted && total_r != COUNT_MAX) begin
      total_nxt = total_r + COUNT_BITS'(1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = walk_acc ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = walk_more ? ST_READ : ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    in_ch.ready = (state_r == ST_IDLE);
    load_out    = (state_r == ST_EMIT) && out_free;
    in_fire     = in_ch.valid && in_ch.ready;
    wr_en       = in_fire && !byte_delim && room;
  end

  // Hold the current word
  pwc_word_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (len_r[ADDR_W-1:0]),
    .wr_data   (byte_folded),
    .rd_addr_a (lo_r),
    .rd_addr_b (hi_r),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
      len_chk_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIN_LENGTH:      min_len_r <= cfg_wdata;
        CFG_LENGTH_CHECK_ON: len_chk_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer state and word control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        len_r <= len_acc;
        ovf_r <= ovf_acc;
      end else if (load_out) begin
        total_r <= total_nxt;
        // drop the closed word
        if (done_r) begin
          len_r <= '0;
          ovf_r <= 1'b0;
        end
      end
    end
  end

  // Walk pointers and match flag
  always_ff @(posedge clk) begin
    if (in_fire) begin
      done_r  <= close_acc;
      match_r <= 1'b1;
      lo_r    <= '0;
      hi_r    <= hi_start[ADDR_W-1:0];
    end else if (state_r == ST_CMP) begin
      if (!pair_eq) begin
        match_r <= 1'b0;
      end
      lo_r <= lo_inc[ADDR_W-1:0];
      hi_r <= hi_dec[ADDR_W-1:0];
    end
  end

  // Result register: hold until the sink takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_done_r    <= done_r;
      out_counted_r <= counted;
      out_count_r   <= total_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.word_done        = out_done_r;
  assign out_ch.word_counted     = out_counted_r;
  assign out_ch.palindrome_count = out_count_r;

endmodule

>>> rtl/pwc_word_store.sv
module pwc_word_store import pwc_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [BYTE_W-1:0] rd_data_a,
  output logic [BYTE_W-1:0] rd_data_b
);

  logic [BYTE_W-1:0] mem [MAX_WORD];

  // Write one byte of the current word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of both ends of the compare window
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> tb/pwc_word_checker.sv
module pwc_word_checker import pwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pwc_in_if                     in_ch,
  pwc_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatch_count,
  output int unsigned           results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  word_done;
    logic                  word_counted;
    logic [COUNT_BITS-1:0] palindrome_count;
  } word_result_t;

  // Shadow of the word being assembled, the count and the registers
  logic [BYTE_W-1:0]     word_bytes [MAX_WORD];
  logic [LEN_W-1:0]      word_len;
  logic                  word_too_long;
  logic [COUNT_BITS-1:0] palin_total;
  logic [CFG_DATA_W-1:0] min_len_cfg;
  logic                  len_rule_on;
  word_result_t          awaited_words [$];
  int unsigned           errors = 0;

  function automatic logic ends_word(input logic [BYTE_W-1:0] b);
    case (b)
      " ", ":", ",", ";", ".", "-", "\n", "\t", "\r", "#", 8'h00: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Walk inward from both ends of the stored word
  function automatic logic word_is_mirror();
    int lo;
    int hi;
    lo = 0;
    hi = int'(word_len) - 1;
    while (lo < hi) begin
      if (word_bytes[lo] != word_bytes[hi]) return 1'b0;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  // Close the pending word, if there is one, and bump the count on a hit
  task automatic close_word(output logic closed, output logic counted);
    logic hit;
    closed  = 1'b0;
    counted = 1'b0;
    if (word_len != 0 || word_too_long) begin
      hit = !word_too_long && word_is_mirror();
      if (len_rule_on && word_len <= min_len_cfg) hit = 1'b0;
      if (hit && palin_total != COUNT_MAX) palin_total++;
      closed        = 1'b1;
      counted       = hit;
      word_len      = '0;
      word_too_long = 1'b0;
    end
  endtask

  task automatic predict_beat(input logic [BYTE_W-1:0] raw, input logic eot,
                              output word_result_t res);
    logic [BYTE_W-1:0] folded;
    logic              closed;
    logic              counted;
    closed  = 1'b0;
    counted = 1'b0;
    if (ends_word(raw)) begin
      close_word(closed, counted);
    end else begin
      folded = (raw >= CH_UPPER_A && raw <= CH_UPPER_Z) ? raw + CASE_DELTA : raw;
      // Keep the first MAX_WORD bytes, drop the rest and flag the word
      if (word_len < MAX_WORD) begin
        word_bytes[word_len[ADDR_W-1:0]] = folded;
        word_len++;
      end else begin
        word_too_long = 1'b1;
      end
    end
    if (eot && !closed) close_word(closed, counted);
    res.word_done        = closed;
    res.word_counted     = closed && counted;
    res.palindrome_count = palin_total;
  endtask

  always @(posedge clk) begin
    word_result_t want;
    word_result_t got;
    word_result_t fresh;
    if (!rst_n) begin
      word_len      = '0;
      word_too_long = 1'b0;
      palin_total   = '0;
      min_len_cfg   = MIN_LEN_RESET;
      len_rule_on   = 1'b1;
      awaited_words.delete();
    end else begin
      // Track register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_LENGTH:      min_len_cfg = cfg_wdata;
          CFG_LENGTH_CHECK_ON: len_rule_on = cfg_wdata[0];
          default: ;
        endcase
      end

      // Compare a result beat against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.word_done        = out_ch.word_done;
        got.word_counted     = out_ch.word_counted;
        got.palindrome_count = out_ch.palindrome_count;
        if (awaited_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: done=%0b counted=%0b count=%0d",
                   $time, got.word_done, got.word_counted, got.palindrome_count);
        end else begin
          want = awaited_words.pop_front();
          if (got.word_done !== want.word_done) begin
            errors++;
            $display("%0t: word_done mismatch: expected %0b, got %0b",
                     $time, want.word_done, got.word_done);
          end
          if (got.word_counted !== want.word_counted) begin
            errors++;
            $display("%0t: word_counted mismatch: expected %0b, got %0b",
                     $time, want.word_counted, got.word_counted);
          end
          if (got.palindrome_count !== want.palindrome_count) begin
            errors++;
            $display("%0t: palindrome_count mismatch: expected %0d, got %0d",
                     $time, want.palindrome_count, got.palindrome_count);
          end
        end
      end

      // Predict the result of an accepted text beat
      if (in_ch.valid && in_ch.ready) begin
        predict_beat(in_ch.text_byte, in_ch.end_of_text, fresh);
        awaited_words.push_back(fresh);
      end
    end
    results_owed   <= awaited_words.size();
    mismatch_count <= errors;
  end

endmodule

>>> tb/testbench.sv
module testbench import pwc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX  = 2'd3;
  localparam int                   HOLD_OFF_CYCLES = 300;
  localparam int                   LONG_WORD_MAX   = MAX_WORD + 2;
  localparam logic [BYTE_W-1:0]    LOWER_A         = "a";
  localparam logic [BYTE_W-1:0]    LOWER_Z         = "z";
  localparam logic [BYTE_W-1:0]    DIGIT_0         = "0";

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatch_count;
  int unsigned           results_owed;
  int unsigned           idle_pct = 0;
  int unsigned           stall_pct = 0;
  int unsigned           beats_sent = 0;
  logic                  hold_off_req = 1'b0;

  pwc_in_if  in_ch ();
  pwc_out_if out_ch ();

  palindrome_word_counter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pwc_word_checker word_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4ms;
    $display("** palindrome_word_counter_unit: FAILED **");
    $finish;
  end

  // Result side: random backpressure plus an occasional long hold-off
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one text beat, with a random gap ahead of it, and hold until taken
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic eot);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], eot_last && i == s.len() - 1);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] min_len, input logic rule_on,
                            input logic poke_unused);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_wdata <= min_len;
    @(posedge clk);
    cfg_index <= CFG_LENGTH_CHECK_ON;
    cfg_wdata <= CFG_DATA_W'(rule_on);
    @(posedge clk);
    // A write to an unmapped index must leave both registers alone
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED_IDX;
      cfg_wdata <= '0;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Randomly flip the case of a letter, leave other bytes unchanged
  function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] b);
    if ($urandom_range(1) == 0) return b;
    if (b >= LOWER_A && b <= LOWER_Z) return b - CASE_DELTA;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return b + CASE_DELTA;
    return b;
  endfunction

  // Any byte that cannot end a word
  function automatic logic [BYTE_W-1:0] rand_word_byte();
    int sel;
    sel = $urandom_range(9);
    if (sel < 7) return vary_case(LOWER_A + BYTE_W'($urandom_range(25)));
    if (sel == 7) return DIGIT_0 + BYTE_W'($urandom_range(9));
    if (sel == 8) return BYTE_W'($urandom_range(128, 255));
    return BYTE_W'($urandom_range(91, 96));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_break();
    case ($urandom_range(10))
      0:       return " ";
      1:       return ":";
      2:       return ",";
      3:       return ";";
      4:       return ".";
      5:       return "-";
      6:       return "\n";
      7:       return "\t";
      8:       return "\r";
      9:       return "#";
      default: return 8'h00;
    endcase
  endfunction

  // One word, mostly a mirror with mixed case, then its separators or end of text
  task automatic send_word();
    logic [BYTE_W-1:0] word [LONG_WORD_MAX];
    int                len;
    int                pick;
    int                ending;
    int                n_breaks;
    logic              mirrored;
    pick = $urandom_range(99);
    if (pick < 80) len = $urandom_range(1, 8);
    else if (pick < 95) len = $urandom_range(9, 20);
    else len = $urandom_range(MAX_WORD - 4, LONG_WORD_MAX);
    mirrored = ($urandom_range(99) < 65);
    for (int i = 0; i < len; i++) begin
      if (mirrored && i > len - 1 - i) word[i] = vary_case(word[len - 1 - i]);
      else word[i] = rand_word_byte();
    end
    // Spoil some mirrors in a single spot
    if (mirrored && len > 1 && $urandom_range(9) == 0) begin
      word[$urandom_range(len - 1)] = rand_word_byte();
    end
    ending = $urandom_range(19);
    for (int i = 0; i < len; i++) begin
      send_beat(word[i], ending == 0 && i == len - 1);
    end
    if (ending != 0) begin
      n_breaks = $urandom_range(1, 3);
      for (int j = 0; j < n_breaks; j++) begin
        send_beat(pick_break(), ending == 1 && j == n_breaks - 1);
      end
    end
  endtask

  task automatic run_traffic(input int unsigned n_beats);
    int unsigned stop_at;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_beat(BYTE_W'($urandom_range(255)), $urandom_range(15) == 0);
        end
      end else begin
        send_word();
      end
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] min_len, input logic rule_on,
                           input int unsigned idle, input int unsigned stall,
                           input logic hold, input int unsigned n_beats);
    drain();
    set_config(min_len, rule_on, 1'b0);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_off_req = 1'b1;
    run_traffic(n_beats);
  endtask

  initial begin : stimulus
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_MIN_LENGTH;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: case folding at A and Z, short and non mirrors, runs of
    // separators, NUL as a separator, end of text on a word byte, on a
    // separator and with no word pending
    set_config(MIN_LEN_RESET, 1'b1, 1'b1);
    send_text("Aba,zZ;ab.::", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text("[a[", 1'b1);
    send_text("XyX#", 1'b1);
    send_beat("\t", 1'b1);

    // Random traffic across register settings and flow-control mixes
    run_phase(7'd0,   1'b1, 0,  0,  1'b0, 250);
    run_phase(7'd64,  1'b1, 68, 0,  1'b0, 200);
    run_phase(7'h7F,  1'b1, 0,  68, 1'b0, 150);
    run_phase(7'd4,   1'b0, 30, 30, 1'b0, 250);
    run_phase(7'd3,   1'b1, 0,  0,  1'b1, 250);
    run_phase(7'd1,   1'b1, 68, 0,  1'b0, 200);
    run_phase(7'd63,  1'b1, 30, 30, 1'b0, 200);

    drain();
    repeat (2 * MAX_WORD + 16) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("** palindrome_word_counter_unit: PASSED **");
    end else begin
      $display("** palindrome_word_counter_unit: FAILED **");
    end
    $finish;
  end

endmodule
